// File: sv/bhs_pkg.sv
// Package for the bucketed hash set: widths, codes, state types and the
// structs passed between the front end, the job queue and the back end.
// No dependencies.
`timescale 1ns / 1ps

package bhs_pkg;

    // Default geometry
    localparam int BUCKETS_DEF = 11;
    localparam int SLOTS_DEF   = 8;

    // Field widths
    localparam int KEY_W   = 32;
    localparam int IPART_W = 16;
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 23;

    // Bucket field in a queued job covers the largest bucket count (64)
    localparam int BKT_FIELD_W = 6;

    // Saturation limits
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FILL,
        B_SCAN,
        B_DONE
    } t_back_state;

    // Classified transaction waiting for the back end
    typedef struct packed {
        logic                   action;
        logic [KEY_W-1:0]       key;
        logic [BKT_FIELD_W-1:0] bucket;
    } t_job;

    // One result transaction
    typedef struct packed {
        logic             found;
        logic             status;
        logic [CNT_W-1:0] entry_total;
        logic [CNT_W-1:0] nonzero_total;
        logic [SUM_W-1:0] integer_sum;
        logic [SUM_W-1:0] even_sum;
        logic [KEY_W-1:0] largest;
        logic [KEY_W-1:0] smallest;
    } t_result;

endpackage

// File: sv/bhs_front.sv
// Front end: accepts a transaction and computes its bucket, the integer
// part modulo BUCKETS, by reciprocal multiply with a registered quotient.
// Depends on bhs_pkg.
`timescale 1ns / 1ps

module bhs_front #(
    parameter int BUCKETS = bhs_pkg::BUCKETS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_action,
    input  logic [bhs_pkg::KEY_W-1:0] i_key,
    output logic                      o_q_push,
    output bhs_pkg::t_job             o_q_job,
    input  logic                      i_q_full
);

    localparam int RW    = $clog2(BUCKETS);
    localparam int SHIFT = bhs_pkg::IPART_W + RW;
    localparam int MW    = bhs_pkg::IPART_W + 1;
    localparam int PW    = bhs_pkg::IPART_W + MW;
    // Reciprocal of BUCKETS rounded up; exact quotient for any 16-bit part
    localparam logic [MW-1:0] RECIP = MW'(((1 << SHIFT) + BUCKETS - 1) / BUCKETS);

    bhs_pkg::t_front_state r_state, n_state;

    logic                        r_action;
    logic [bhs_pkg::KEY_W-1:0]   r_key;
    logic [bhs_pkg::IPART_W-1:0] r_quo;

    logic                        accept;
    logic [bhs_pkg::IPART_W-1:0] ipart;
    logic [PW-1:0]               quo_prod;
    logic [bhs_pkg::IPART_W-1:0] rem_full;

    assign accept = i_push && !o_full;
    assign ipart  = r_key[bhs_pkg::KEY_W-1:bhs_pkg::KEY_W-bhs_pkg::IPART_W];

    // Quotient by reciprocal, then remainder by multiply and subtract
    assign quo_prod = PW'(ipart) * PW'(RECIP);
    assign rem_full = ipart - r_quo * bhs_pkg::IPART_W'(BUCKETS);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bhs_pkg::F_IDLE: begin
                if (accept) n_state = bhs_pkg::F_HASH;
            end
            bhs_pkg::F_HASH: begin
                n_state = bhs_pkg::F_PUSH;
            end
            bhs_pkg::F_PUSH: begin
                if (!i_q_full) n_state = bhs_pkg::F_IDLE;
            end
            default: n_state = bhs_pkg::F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_full   = (r_state != bhs_pkg::F_IDLE);
        o_q_push = (r_state == bhs_pkg::F_PUSH) && !i_q_full;
    end

    always_comb begin
        o_q_job.action = r_action;
        o_q_job.key    = r_key;
        o_q_job.bucket = bhs_pkg::BKT_FIELD_W'(rem_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhs_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture and hash datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_key    <= i_key;
        end else if (r_state == bhs_pkg::F_HASH) begin
            r_quo <= bhs_pkg::IPART_W'(quo_prod >> SHIFT);
        end
    end

endmodule

// File: sv/bhs_queue.sv
// Short job queue between the front end and the back end.
// Depends on bhs_pkg.
`timescale 1ns / 1ps

module bhs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bhs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output bhs_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int DEPTH = bhs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bhs_pkg::t_job    r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_entry[r_rd_ptr];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: sv/bhs_back.sv
// Back end: bucket fill table, slot memory, running statistics and the
// result register. Depends on bhs_pkg.
`timescale 1ns / 1ps

module bhs_back #(
    parameter int BUCKETS          = bhs_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = bhs_pkg::SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  bhs_pkg::t_job    i_q_job,
    output logic             o_q_pop,
    output bhs_pkg::t_result o_res,
    output logic             o_empty,
    input  logic             i_pop
);

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int DEPTH  = BUCKETS * SLOTS_PER_BUCKET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int KW     = bhs_pkg::KEY_W;
    localparam int IW     = bhs_pkg::IPART_W;
    localparam int CW     = bhs_pkg::CNT_W;
    localparam int SW     = bhs_pkg::SUM_W;

    // Memories
    logic [KW-1:0]     r_slot_mem [DEPTH];
    logic [FILL_W-1:0] r_fill_mem [BUCKETS];
    logic [BUCKETS-1:0] r_fill_vld;

    bhs_pkg::t_back_state r_state, n_state;

    bhs_pkg::t_job     r_job;
    logic [FILL_W-1:0] r_fill_q;
    logic              r_fill_hit;
    logic [FILL_W-1:0] r_fill;
    logic [SLOT_W-1:0] r_idx;
    logic [KW-1:0]     r_slot_q;
    logic              r_found;
    logic              r_status;

    // Statistics
    logic [CW-1:0] r_entry_cnt;
    logic [CW-1:0] r_nonzero_cnt;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] r_even_sum;
    logic [KW-1:0] r_max;
    logic [KW-1:0] r_min;

    bhs_pkg::t_result r_res;
    logic             r_out_vld;

    logic [BKT_W-1:0]  q_bkt, job_bkt;
    logic [ADDR_W-1:0] base_addr, rd_addr, wr_addr;
    logic [SLOT_W-1:0] rd_slot;
    logic [FILL_W-1:0] fill_cur;
    logic [IW-1:0]     ipart;
    logic [SW:0]       sum_ext, even_ext;
    logic              is_insert, bucket_full, slot_hit, scan_last, out_free;
    logic              do_insert, load_out;

    assign q_bkt     = i_q_job.bucket[BKT_W-1:0];
    assign job_bkt   = r_job.bucket[BKT_W-1:0];
    assign base_addr = ADDR_W'(job_bkt * SLOTS_PER_BUCKET);
    assign fill_cur  = r_fill_hit ? r_fill_q : '0;
    assign rd_slot   = (r_state == bhs_pkg::B_FILL) ? '0 : r_idx + 1'b1;
    assign rd_addr   = base_addr + ADDR_W'(rd_slot);
    assign wr_addr   = base_addr + ADDR_W'(fill_cur);
    assign ipart     = r_job.key[KW-1:KW-IW];
    assign is_insert = (r_job.action == bhs_pkg::ACT_INSERT);
    assign bucket_full = (fill_cur >= FILL_W'(SLOTS_PER_BUCKET));
    assign slot_hit  = (r_slot_q == r_job.key);
    assign scan_last = ((FILL_W'(r_idx) + 1'b1) >= r_fill);
    assign out_free  = !r_out_vld || i_pop;
    assign sum_ext   = {1'b0, r_sum} + (SW+1)'(ipart);
    assign even_ext  = {1'b0, r_even_sum} + (SW+1)'(ipart);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bhs_pkg::B_IDLE: begin
                if (!i_q_empty) n_state = bhs_pkg::B_FILL;
            end
            bhs_pkg::B_FILL: begin
                if (is_insert || fill_cur == '0) begin
                    n_state = bhs_pkg::B_DONE;
                end else begin
                    n_state = bhs_pkg::B_SCAN;
                end
            end
            bhs_pkg::B_SCAN: begin
                if (slot_hit || scan_last) n_state = bhs_pkg::B_DONE;
            end
            bhs_pkg::B_DONE: begin
                if (out_free) n_state = bhs_pkg::B_IDLE;
            end
            default: n_state = bhs_pkg::B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_q_pop   = (r_state == bhs_pkg::B_IDLE) && !i_q_empty;
        do_insert = (r_state == bhs_pkg::B_FILL) && is_insert && !bucket_full;
        load_out  = (r_state == bhs_pkg::B_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhs_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Fill table: read every cycle at the head job's bucket
    always_ff @(posedge i_clk) begin
        r_fill_q <= r_fill_mem[q_bkt];
        if (do_insert) begin
            r_fill_mem[job_bkt] <= fill_cur + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_vld <= '0;
            r_fill_hit <= 1'b0;
        end else begin
            r_fill_hit <= r_fill_vld[q_bkt];
            if (do_insert) r_fill_vld[job_bkt] <= 1'b1;
        end
    end

    // Slot memory: one read and one write port
    always_ff @(posedge i_clk) begin
        r_slot_q <= r_slot_mem[rd_addr];
        if (do_insert) begin
            r_slot_mem[wr_addr] <= r_job.key;
        end
    end

    // Job tracking and scan
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job    <= i_q_job;
            r_found  <= 1'b0;
            r_status <= bhs_pkg::STAT_OK;
        end
        unique case (r_state)
            bhs_pkg::B_FILL: begin
                r_fill <= fill_cur;
                r_idx  <= '0;
                if (is_insert && bucket_full) r_status <= bhs_pkg::STAT_FULL;
            end
            bhs_pkg::B_SCAN: begin
                if (slot_hit) begin
                    r_found <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            bhs_pkg::B_IDLE, bhs_pkg::B_DONE: ;
            default: ;
        endcase
    end

    // Running statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_cnt   <= '0;
            r_nonzero_cnt <= '0;
            r_sum         <= '0;
            r_even_sum    <= '0;
            r_max         <= '0;
            r_min         <= '0;
        end else if (do_insert) begin
            if (r_entry_cnt == '0) begin
                r_max <= r_job.key;
                r_min <= r_job.key;
            end else begin
                if (r_job.key > r_max) r_max <= r_job.key;
                if (r_job.key < r_min) r_min <= r_job.key;
            end
            if (r_entry_cnt != bhs_pkg::CNT_MAX) r_entry_cnt <= r_entry_cnt + 1'b1;
            if (r_job.key != '0 && r_nonzero_cnt != bhs_pkg::CNT_MAX) begin
                r_nonzero_cnt <= r_nonzero_cnt + 1'b1;
            end
            r_sum <= sum_ext[SW] ? bhs_pkg::SUM_MAX : sum_ext[SW-1:0];
            if (!ipart[0]) begin
                r_even_sum <= even_ext[SW] ? bhs_pkg::SUM_MAX : even_ext[SW-1:0];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res.found         <= r_found;
            r_res.status        <= r_status;
            r_res.entry_total   <= r_entry_cnt;
            r_res.nonzero_total <= r_nonzero_cnt;
            r_res.integer_sum   <= r_sum;
            r_res.even_sum      <= r_even_sum;
            r_res.largest       <= r_max;
            r_res.smallest      <= r_min;
        end
    end

    assign o_res   = r_res;
    assign o_empty = !r_out_vld;

endmodule

// File: sv/bucketed_hash_set_with_stats.sv
// Bucketed hash set with running statistics: front end (modulo hash),
// two-entry job queue, back end (fill table, slot memory, statistics).
// An insert, or a search of an empty bucket, goes from the fill lookup
// straight to the result; any other search first scans the bucket's slots.
// The front end accepts a new transaction before earlier ones have finished.
// Reset: synchronous, active low; clears all counts, no memory sweep.
`timescale 1ns / 1ps

module bucketed_hash_set_with_stats #(
    parameter int BUCKETS          = bhs_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = bhs_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_action,
    input  logic [bhs_pkg::KEY_W-1:0] i_key,
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_found,
    output logic                      o_status,
    output logic [bhs_pkg::CNT_W-1:0] o_entry_total,
    output logic [bhs_pkg::CNT_W-1:0] o_nonzero_total,
    output logic [bhs_pkg::SUM_W-1:0] o_integer_sum,
    output logic [bhs_pkg::SUM_W-1:0] o_even_sum,
    output logic [bhs_pkg::KEY_W-1:0] o_largest,
    output logic [bhs_pkg::KEY_W-1:0] o_smallest
);

    bhs_pkg::t_job    f_job, q_job;
    bhs_pkg::t_result res;
    logic             q_push, q_full, q_pop, q_empty;

    bhs_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_action (i_action),
        .i_key    (i_key),
        .o_q_push (q_push),
        .o_q_job  (f_job),
        .i_q_full (q_full)
    );

    bhs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    bhs_back #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_res     (res),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    assign o_found         = res.found;
    assign o_status        = res.status;
    assign o_entry_total   = res.entry_total;
    assign o_nonzero_total = res.nonzero_total;
    assign o_integer_sum   = res.integer_sum;
    assign o_even_sum      = res.even_sum;
    assign o_largest       = res.largest;
    assign o_smallest      = res.smallest;

    // Front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    // Back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    // Reported entry count never decreases across results
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && $past(!empty) && $past(i_rst_n)) |->
            (o_entry_total >= $past(o_entry_total)))
        else $error("entry count went backwards");

endmodule
